>>> rtl/gclb_pkg.sv
// gclb_pkg: command, status and register codes, fixed field widths and reset
// values for the grid cell list binner. No dependencies.
`default_nettype none

package gclb_pkg;

    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int SIDE_W  = 5;
    localparam int SIZE_W  = 24;
    localparam int REG_W   = 2;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MOVE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_OFF  = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd3;

    localparam logic [REG_W-1:0] REG_ACROSS = 2'd0;
    localparam logic [REG_W-1:0] REG_DOWN   = 2'd1;
    localparam logic [REG_W-1:0] REG_WIDTH  = 2'd2;
    localparam logic [REG_W-1:0] REG_HEIGHT = 2'd3;

    localparam logic [SIDE_W-1:0] RST_SIDE = 5'd16;
    localparam logic [SIZE_W-1:0] RST_SIZE = 24'd12800;

endpackage

`default_nettype wire

>>> rtl/grid_cell_list_binner.sv
// grid_cell_list_binner: bins points into a grid with per-cell linked lists
// depends on gclb_pkg
//
// channel   | signals                                    | handshake
// request   | i_command i_pos_x i_pos_y i_point_index    | i_start & !o_busy
// result    | o_status o_found o_point_out o_cell_out    | o_valid strobe, o_last
// config    | i_cfg_index i_cfg_data                     | i_cfg_valid & o_cfg_ready
//
// the position is located by one shared compare/subtract unit, x then y; add
// then reads the cell head and links in, move first unlinks, a query walks the
// cells and their points; each link memory has one read and one write port
// reset and every config write start a clearing pass over the cell head
// memory, during which o_busy is high
// results cannot be stalled; a new request is taken only once o_busy falls
`default_nettype none

module grid_cell_list_binner #(
    parameter int MAX_POINTS = 64,
    parameter int MAX_SIDE   = 16,
    parameter int POS_BITS   = 24
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    output logic                                   o_busy,
    input  wire logic [gclb_pkg::CMD_W-1:0]        i_command,
    input  wire logic [POS_BITS-1:0]               i_pos_x,
    input  wire logic [POS_BITS-1:0]               i_pos_y,
    input  wire logic [$clog2(MAX_POINTS)-1:0]     i_point_index,
    output logic                                   o_valid,
    output logic [gclb_pkg::STAT_W-1:0]            o_status,
    output logic                                   o_found,
    output logic [$clog2(MAX_POINTS)-1:0]          o_point_out,
    output logic [2*((MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1)-1:0] o_cell_out,
    output logic                                   o_last,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [gclb_pkg::REG_W-1:0]        i_cfg_index,
    input  wire logic [gclb_pkg::SIZE_W-1:0]       i_cfg_data
);

    localparam int IW        = $clog2(MAX_POINTS);
    localparam int LW        = $clog2(MAX_POINTS + 1);
    localparam int SW        = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int NW        = SW + 1;
    localparam int CW        = 2 * SW;
    localparam int QW        = SW + 2;
    localparam int NUM_CELLS = MAX_SIDE * MAX_SIDE;
    localparam int DW        = (POS_BITS > gclb_pkg::SIZE_W) ? POS_BITS : gclb_pkg::SIZE_W;
    localparam logic [LW-1:0] NIL = LW'(MAX_POINTS);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DIVX, S_DIVY, S_DECIDE, S_MV_RD, S_MV_CHK,
        S_HEAD_RD, S_LINK1, S_LINK2, S_Q_CELL, S_Q_NODE, S_Q_END
    } t_state;

    // config registers
    logic [gclb_pkg::SIDE_W-1:0] r_across, r_down;
    logic [gclb_pkg::SIZE_W-1:0] r_cw, r_ch;

    t_state r_state, n_state;
    logic [gclb_pkg::CMD_W-1:0] r_cmd, n_cmd;
    logic [POS_BITS-1:0] r_py, n_py;
    logic [IW-1:0] r_idx, n_idx;
    logic [LW-1:0] r_count, n_count;
    logic [DW-1:0] r_rem, n_rem;
    logic [QW-1:0] r_q, n_q;
    logic [SW-1:0] r_col, n_col, r_row, n_row;
    logic r_off, n_off;
    logic [CW-1:0] r_cell, n_cell;
    logic [LW-1:0] r_h, n_h;
    logic r_from_head, n_from_head;
    logic [1:0] r_dw, n_dw, r_dh, n_dh;
    logic [CW-1:0] r_qc, n_qc;
    logic r_pend_v, n_pend_v;
    logic [IW-1:0] r_pend_pt, n_pend_pt;
    logic [CW-1:0] r_pend_cell, n_pend_cell;
    logic [CW-1:0] r_clr, n_clr;

    logic n_o_valid, n_o_found, n_o_last;
    logic [gclb_pkg::STAT_W-1:0] n_o_status;
    logic [IW-1:0] n_o_point;
    logic [CW-1:0] n_o_cell;

    // memories
    logic [LW-1:0] m_head [NUM_CELLS];
    logic [LW-1:0] m_next [MAX_POINTS];
    logic [LW-1:0] m_prev [MAX_POINTS];
    logic [CW-1:0] m_pcell [MAX_POINTS];
    logic [LW-1:0] r_head_rd, r_next_rd, r_prev_rd;
    logic [CW-1:0] r_pcell_rd;

    logic hw_en, nw_en, pw_en, cw_en;
    logic [CW-1:0] hw_addr, hr_addr;
    logic [LW-1:0] hw_data, nw_data, pw_data;
    logic [IW-1:0] nw_addr, pw_addr, nr_addr;

    logic cfg_we;
    logic [6:0] cols_w, rows_w;
    logic [NW-1:0] cols, rows, lim;
    logic [DW-1:0] div_x, div_y, div_sel;
    logic step_go, q_over;
    logic [QW-1:0] q_clamp;
    logic [CW:0] cell_prod, q_prod;
    logic [CW-1:0] cell_now, qcell;
    logic [QW-1:0] wp, hp;
    logic [SW-1:0] wm1, hm1;
    logic q_valid, q_lastcell;
    logic [LW-1:0] node;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign o_busy      = (r_state != S_IDLE);

    // clamp grid sides to 1..MAX_SIDE
    always_comb begin
        if (r_across == '0) begin
            cols_w = 7'd1;
        end else if ({2'b00, r_across} > 7'(MAX_SIDE)) begin
            cols_w = 7'(MAX_SIDE);
        end else begin
            cols_w = {2'b00, r_across};
        end
        if (r_down == '0) begin
            rows_w = 7'd1;
        end else if ({2'b00, r_down} > 7'(MAX_SIDE)) begin
            rows_w = 7'(MAX_SIDE);
        end else begin
            rows_w = {2'b00, r_down};
        end
    end
    assign cols = cols_w[NW-1:0];
    assign rows = rows_w[NW-1:0];

    // shared compare/subtract unit for the floor division
    assign div_x   = (r_cw == '0) ? DW'(1) : DW'(r_cw);
    assign div_y   = (r_ch == '0) ? DW'(1) : DW'(r_ch);
    assign div_sel = (r_state == S_DIVY) ? div_y : div_x;
    assign lim     = (r_state == S_DIVY) ? rows : cols;
    assign step_go = (r_rem >= div_sel) && (r_q <= QW'(lim));
    assign q_over  = r_q > QW'(lim);
    assign q_clamp = (r_q == QW'(lim)) ? (r_q - QW'(1)) : r_q;

    assign cell_prod = (CW+1)'(r_row) * (CW+1)'(cols);
    assign cell_now  = cell_prod[CW-1:0] + CW'(r_col);

    // neighborhood cell walk
    assign wp = QW'(r_col) + QW'(r_dw);
    assign hp = QW'(r_row) + QW'(r_dh);
    assign q_valid = (wp != '0) && (wp <= QW'(cols)) && (hp != '0) && (hp <= QW'(rows));
    assign wm1 = SW'(wp - QW'(1));
    assign hm1 = SW'(hp - QW'(1));
    assign q_prod = (CW+1)'(hm1) * (CW+1)'(cols);
    assign qcell  = q_prod[CW-1:0] + CW'(wm1);
    assign q_lastcell = (r_dw == 2'd2) && (r_dh == 2'd2);
    assign node = r_from_head ? r_head_rd : r_next_rd;

    assign hr_addr = (r_state == S_Q_CELL) ? qcell : r_cell;
    assign nr_addr = (r_state == S_Q_NODE) ? node[IW-1:0] : r_idx;

    always_comb begin
        n_state = r_state;   n_cmd = r_cmd;       n_py = r_py;       n_idx = r_idx;
        n_count = r_count;   n_rem = r_rem;       n_q = r_q;         n_col = r_col;
        n_row = r_row;       n_off = r_off;       n_cell = r_cell;   n_h = r_h;
        n_from_head = r_from_head;                n_dw = r_dw;       n_dh = r_dh;
        n_qc = r_qc;         n_pend_v = r_pend_v; n_pend_pt = r_pend_pt;
        n_pend_cell = r_pend_cell;                n_clr = r_clr;
        n_o_valid = 1'b0;    n_o_status = gclb_pkg::ST_OK;
        n_o_found = 1'b0;    n_o_point = '0;      n_o_cell = '0;     n_o_last = 1'b0;
        hw_en = 1'b0; hw_addr = r_cell; hw_data = NIL;
        nw_en = 1'b0; nw_addr = r_idx;  nw_data = NIL;
        pw_en = 1'b0; pw_addr = r_idx;  pw_data = NIL;
        cw_en = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                hw_en   = 1'b1;
                hw_addr = r_clr;
                hw_data = NIL;
                n_clr   = r_clr + CW'(1);
                if (r_clr == CW'(NUM_CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_cmd   = i_command;
                    n_py    = i_pos_y;
                    n_idx   = i_point_index;
                    n_rem   = DW'(i_pos_x);
                    n_q     = '0;
                    n_state = S_DIVX;
                end
            end
            S_DIVX: begin
                if (step_go) begin
                    n_rem = r_rem - div_sel;
                    n_q   = r_q + QW'(1);
                end else begin
                    n_off   = q_over;
                    n_col   = q_clamp[SW-1:0];
                    n_rem   = DW'(r_py);
                    n_q     = '0;
                    n_state = S_DIVY;
                end
            end
            S_DIVY: begin
                if (step_go) begin
                    n_rem = r_rem - div_sel;
                    n_q   = r_q + QW'(1);
                end else begin
                    n_off   = r_off || q_over;
                    n_row   = q_clamp[SW-1:0];
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_cell = cell_now;
                case (r_cmd)
                    gclb_pkg::CMD_ADD: begin
                        if (r_count == NIL) begin
                            n_o_valid = 1'b1; n_o_status = gclb_pkg::ST_FULL;
                            n_o_last = 1'b1;  n_state = S_IDLE;
                        end else if (r_off) begin
                            n_o_valid = 1'b1; n_o_status = gclb_pkg::ST_OFF;
                            n_o_last = 1'b1;  n_state = S_IDLE;
                        end else begin
                            n_idx   = r_count[IW-1:0];
                            n_state = S_HEAD_RD;
                        end
                    end
                    gclb_pkg::CMD_MOVE: begin
                        if (LW'(r_idx) >= r_count) begin
                            n_o_valid = 1'b1; n_o_status = gclb_pkg::ST_BAD;
                            n_o_last = 1'b1;  n_state = S_IDLE;
                        end else if (r_off) begin
                            n_o_valid = 1'b1; n_o_status = gclb_pkg::ST_OFF;
                            n_o_last = 1'b1;  n_state = S_IDLE;
                        end else begin
                            n_state = S_MV_RD;
                        end
                    end
                    gclb_pkg::CMD_QUERY: begin
                        if (r_off) begin
                            n_o_valid = 1'b1; n_o_status = gclb_pkg::ST_OFF;
                            n_o_last = 1'b1;  n_state = S_IDLE;
                        end else begin
                            n_dw = 2'd0; n_dh = 2'd0; n_pend_v = 1'b0;
                            n_state = S_Q_CELL;
                        end
                    end
                    default: begin
                        n_o_valid = 1'b1; n_o_last = 1'b1; n_state = S_IDLE;
                    end
                endcase
            end
            S_MV_RD: begin
                n_state = S_MV_CHK;
            end
            S_MV_CHK: begin
                if (r_pcell_rd == r_cell) begin
                    n_o_valid = 1'b1; n_o_found = 1'b1; n_o_point = r_idx;
                    n_o_cell = r_cell; n_o_last = 1'b1; n_state = S_IDLE;
                end else begin
                    // unlink from the old cell
                    if (r_prev_rd < NIL) begin
                        nw_en   = 1'b1;
                        nw_addr = r_prev_rd[IW-1:0];
                        nw_data = r_next_rd;
                    end else if ((CW+1)'(r_pcell_rd) < (CW+1)'(NUM_CELLS)) begin
                        hw_en   = 1'b1;
                        hw_addr = r_pcell_rd;
                        hw_data = r_next_rd;
                    end
                    if (r_next_rd < NIL) begin
                        pw_en   = 1'b1;
                        pw_addr = r_next_rd[IW-1:0];
                        pw_data = r_prev_rd;
                    end
                    n_state = S_HEAD_RD;
                end
            end
            S_HEAD_RD: begin
                n_state = S_LINK1;
            end
            S_LINK1: begin
                n_h = r_head_rd;
                nw_en = 1'b1; nw_addr = r_idx; nw_data = r_head_rd;
                pw_en = 1'b1; pw_addr = r_idx; pw_data = NIL;
                cw_en = 1'b1;
                hw_en = 1'b1; hw_addr = r_cell; hw_data = LW'(r_idx);
                if (r_cmd == gclb_pkg::CMD_ADD) begin
                    n_count = r_count + LW'(1);
                end
                n_state = S_LINK2;
            end
            S_LINK2: begin
                if (r_h != NIL) begin
                    pw_en = 1'b1; pw_addr = r_h[IW-1:0]; pw_data = LW'(r_idx);
                end
                n_o_valid = 1'b1; n_o_found = 1'b1; n_o_point = r_idx;
                n_o_cell = r_cell; n_o_last = 1'b1; n_state = S_IDLE;
            end
            S_Q_CELL: begin
                if (q_valid) begin
                    n_qc        = qcell;
                    n_from_head = 1'b1;
                    n_state     = S_Q_NODE;
                end else if (q_lastcell) begin
                    n_state = S_Q_END;
                end else if (r_dh == 2'd2) begin
                    n_dh = 2'd0; n_dw = r_dw + 2'd1;
                end else begin
                    n_dh = r_dh + 2'd1;
                end
            end
            S_Q_NODE: begin
                if (node < NIL) begin
                    if (r_pend_v) begin
                        n_o_valid = 1'b1; n_o_found = 1'b1;
                        n_o_point = r_pend_pt; n_o_cell = r_pend_cell;
                    end
                    n_pend_v    = 1'b1;
                    n_pend_pt   = node[IW-1:0];
                    n_pend_cell = r_qc;
                    n_from_head = 1'b0;
                end else if (q_lastcell) begin
                    n_state = S_Q_END;
                end else begin
                    if (r_dh == 2'd2) begin
                        n_dh = 2'd0; n_dw = r_dw + 2'd1;
                    end else begin
                        n_dh = r_dh + 2'd1;
                    end
                    n_state = S_Q_CELL;
                end
            end
            S_Q_END: begin
                n_o_valid = 1'b1;
                n_o_last  = 1'b1;
                if (r_pend_v) begin
                    n_o_found = 1'b1; n_o_point = r_pend_pt; n_o_cell = r_pend_cell;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a config write clears the table
        if (cfg_we) begin
            n_state = S_CLEAR;
            n_clr   = '0;
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_count  <= '0;
            r_across <= gclb_pkg::RST_SIDE;
            r_down   <= gclb_pkg::RST_SIDE;
            r_cw     <= gclb_pkg::RST_SIZE;
            r_ch     <= gclb_pkg::RST_SIZE;
            r_pend_v <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_count  <= n_count;
            r_pend_v <= n_pend_v;
            o_valid  <= n_o_valid;
            if (cfg_we) begin
                unique case (i_cfg_index)
                    gclb_pkg::REG_ACROSS: r_across <= i_cfg_data[gclb_pkg::SIDE_W-1:0];
                    gclb_pkg::REG_DOWN:   r_down   <= i_cfg_data[gclb_pkg::SIDE_W-1:0];
                    gclb_pkg::REG_WIDTH:  r_cw     <= i_cfg_data;
                    gclb_pkg::REG_HEIGHT: r_ch     <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_cmd       <= n_cmd;
        r_py        <= n_py;
        r_idx       <= n_idx;
        r_rem       <= n_rem;
        r_q         <= n_q;
        r_col       <= n_col;
        r_row       <= n_row;
        r_off       <= n_off;
        r_cell      <= n_cell;
        r_h         <= n_h;
        r_from_head <= n_from_head;
        r_dw        <= n_dw;
        r_dh        <= n_dh;
        r_qc        <= n_qc;
        r_pend_pt   <= n_pend_pt;
        r_pend_cell <= n_pend_cell;
        o_status    <= n_o_status;
        o_found     <= n_o_found;
        o_point_out <= n_o_point;
        o_cell_out  <= n_o_cell;
        o_last      <= n_o_last;
    end

    always_ff @(posedge i_clk) begin
        if (hw_en) begin
            m_head[hw_addr] <= hw_data;
        end
        r_head_rd <= m_head[hr_addr];
    end

    always_ff @(posedge i_clk) begin
        if (nw_en) begin
            m_next[nw_addr] <= nw_data;
        end
        r_next_rd <= m_next[nr_addr];
    end

    always_ff @(posedge i_clk) begin
        if (pw_en) begin
            m_prev[pw_addr] <= pw_data;
        end
        r_prev_rd <= m_prev[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (cw_en) begin
            m_pcell[r_idx] <= r_cell;
        end
        r_pcell_rd <= m_pcell[r_idx];
    end

endmodule

`default_nettype wire

>>> rtl/gclb_check.sv
// gclb_check: port-level checks for grid_cell_list_binner, bound to the top
// depends on gclb_pkg
`default_nettype none

module gclb_check #(
    parameter int IW = 6,
    parameter int CW = 8
) (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_start,
    input wire logic                         o_busy,
    input wire logic                         o_valid,
    input wire logic [gclb_pkg::STAT_W-1:0]  o_status,
    input wire logic                         o_found,
    input wire logic [IW-1:0]                o_point_out,
    input wire logic [CW-1:0]                o_cell_out,
    input wire logic                         o_last
);

    // every result comes from a request in flight
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(o_busy))
        else $error("result without request in flight");

    // error results are single and empty
    a_err_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != gclb_pkg::ST_OK) |->
            (!o_found && o_point_out == '0 && o_cell_out == '0 && o_last))
        else $error("error result carries data");

    // an accepted request makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("request accepted but not busy");

    // more results follow a non-final one
    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> o_busy)
        else $error("non-final result while idle");

endmodule

bind grid_cell_list_binner gclb_check #(
    .IW($clog2(MAX_POINTS)),
    .CW(2 * ((MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1))
) u_gclb_check (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_start(i_start),
    .o_busy(o_busy),
    .o_valid(o_valid),
    .o_status(o_status),
    .o_found(o_found),
    .o_point_out(o_point_out),
    .o_cell_out(o_cell_out),
    .o_last(o_last)
);

`default_nettype wire

>>> bench/gclb_checker.sv
// gclb_checker: watches the request, result and config channels of the
// grid cell list binner, keeps its own copy of the grid lists and compares
// every result against the predicted one. depends on gclb_pkg
module gclb_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_busy,
    input  wire logic [1:0]  i_command,
    input  wire logic [23:0] i_pos_x,
    input  wire logic [23:0] i_pos_y,
    input  wire logic [5:0]  i_point_index,
    input  wire logic        i_valid,
    input  wire logic [1:0]  i_status,
    input  wire logic        i_found,
    input  wire logic [5:0]  i_point_out,
    input  wire logic [7:0]  i_cell_out,
    input  wire logic        i_last,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_data,
    output int               o_errors,
    output int               o_pending,
    output int               o_points,
    output int               o_results,
    output int               o_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS = 64;
    localparam int SIDE = 16;
    localparam int EXP_DEPTH = 256;
    localparam logic [6:0] NIL = 7'd64;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [5:0] pt;
        logic [7:0] cell_no;
        logic       last;
    } t_bin_result;

    t_bin_result exp_buf [EXP_DEPTH];
    int          exp_wr = 0;
    int          exp_rd = 0;

    logic [4:0]  across, down;
    logic [23:0] cw, ch;
    logic [6:0]  head [SIDE*SIDE];
    logic [6:0]  nxt [NPTS];
    logic [6:0]  prv [NPTS];
    logic [7:0]  pcell [NPTS];
    int          count;

    function automatic int side_eff(logic [4:0] v);
        if (v == 0) return 1;
        if (v > SIDE) return SIDE;
        return int'(v);
    endfunction

    function automatic bit axis(logic [23:0] p, logic [23:0] sz, int n, output int q);
        longint unsigned v;
        v = longint'(p) / ((sz == 0) ? 1 : longint'(sz));
        if (v == n) v = n - 1;
        q = int'(v);
        return v < n;
    endfunction

    task automatic clear_grid();
        for (int i = 0; i < SIDE*SIDE; i++) head[i] = NIL;
        count = 0;
    endtask

    task automatic link_in(int idx, int c);
        logic [6:0] h;
        h = head[c];
        if (h < NIL) prv[h] = 7'(idx);
        nxt[idx] = h;
        prv[idx] = NIL;
        pcell[idx] = 8'(c);
        head[c] = 7'(idx);
    endtask

    task automatic unlink_out(int idx);
        logic [6:0] p, n;
        p = prv[idx];
        n = nxt[idx];
        if (p < NIL) nxt[p] = n;
        else head[pcell[idx]] = n;
        if (n < NIL) prv[n] = p;
    endtask

    task automatic push(logic [1:0] st, logic f, int pt, int c, logic l);
        t_bin_result r;
        r.status = st;
        r.found = f;
        r.pt = 6'(pt);
        r.cell_no = 8'(c);
        r.last = l;
        exp_buf[exp_wr % EXP_DEPTH] = r;
        exp_wr++;
    endtask

    task automatic predict_request(logic [1:0] cmd, logic [23:0] x, logic [23:0] y,
                                   logic [5:0] pidx);
        int col, row, cols, rows, c, k, g;
        bit on, okx, oky;
        logic [6:0] n;
        cols = side_eff(across);
        rows = side_eff(down);
        okx = axis(x, cw, cols, col);
        oky = axis(y, ch, rows, row);
        on = okx && oky;
        c = row * cols + col;
        case (cmd)
            gclb_pkg::CMD_ADD: begin
                if (count >= NPTS) push(gclb_pkg::ST_FULL, 0, 0, 0, 1);
                else if (!on) push(gclb_pkg::ST_OFF, 0, 0, 0, 1);
                else begin
                    link_in(count, c);
                    push(gclb_pkg::ST_OK, 1, count, c, 1);
                    count++;
                end
            end
            gclb_pkg::CMD_MOVE: begin
                if (int'(pidx) >= count) push(gclb_pkg::ST_BAD, 0, 0, 0, 1);
                else if (!on) push(gclb_pkg::ST_OFF, 0, 0, 0, 1);
                else begin
                    if (pcell[pidx] != 8'(c)) begin
                        unlink_out(pidx);
                        link_in(pidx, c);
                    end
                    push(gclb_pkg::ST_OK, 1, pidx, c, 1);
                end
            end
            gclb_pkg::CMD_QUERY: begin
                if (!on) push(gclb_pkg::ST_OFF, 0, 0, 0, 1);
                else begin
                    k = 0;
                    for (int w = col - 1; w <= col + 1; w++) begin
                        for (int h = row - 1; h <= row + 1; h++) begin
                            if (w < 0 || w >= cols || h < 0 || h >= rows) continue;
                            c = h * cols + w;
                            n = head[c];
                            g = 0;
                            while (n < NIL && g < NPTS && k < NPTS) begin
                                push(gclb_pkg::ST_OK, 1, n, c, 0);
                                n = nxt[n];
                                g++;
                                k++;
                            end
                        end
                    end
                    if (k == 0) push(gclb_pkg::ST_OK, 0, 0, 0, 1);
                    else begin
                        exp_buf[(exp_wr - 1) % EXP_DEPTH].last = 1;
                        o_hits += k;
                    end
                end
            end
            default: push(gclb_pkg::ST_OK, 0, 0, 0, 1);
        endcase
    endtask

    initial begin
        o_errors = 0;
        o_results = 0;
        o_hits = 0;
    end

    assign o_pending = exp_wr - exp_rd;
    assign o_points = count;

    always @(posedge i_clk) begin
        t_bin_result e;
        if (!i_rst_n) begin
            across = gclb_pkg::RST_SIDE;
            down = gclb_pkg::RST_SIDE;
            cw = gclb_pkg::RST_SIZE;
            ch = gclb_pkg::RST_SIZE;
            clear_grid();
            exp_rd = exp_wr;
        end else begin
            if (i_valid) begin
                o_results++;
                if (exp_wr == exp_rd) begin
                    $display("%0t: result with nothing expected: st %0d found %0d pt %0d cell %0d",
                             $time, i_status, i_found, i_point_out, i_cell_out);
                    o_errors++;
                end else begin
                    e = exp_buf[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (i_status !== e.status) begin
                        $display("%0t: status expected %0d actual %0d", $time, e.status, i_status);
                        o_errors++;
                    end
                    if (i_found !== e.found) begin
                        $display("%0t: found expected %0d actual %0d", $time, e.found, i_found);
                        o_errors++;
                    end
                    if (i_point_out !== e.pt) begin
                        $display("%0t: point expected %0d actual %0d", $time, e.pt, i_point_out);
                        o_errors++;
                    end
                    if (i_cell_out !== e.cell_no) begin
                        $display("%0t: cell expected %0d actual %0d", $time, e.cell_no,
                                 i_cell_out);
                        o_errors++;
                    end
                    if (i_last !== e.last) begin
                        $display("%0t: last expected %0d actual %0d", $time, e.last, i_last);
                        o_errors++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    gclb_pkg::REG_ACROSS: across = i_cfg_data[4:0];
                    gclb_pkg::REG_DOWN:   down = i_cfg_data[4:0];
                    gclb_pkg::REG_WIDTH:  cw = i_cfg_data;
                    default:              ch = i_cfg_data;
                endcase
                clear_grid();
            end
            if (i_start && !i_busy)
                predict_request(i_command, i_pos_x, i_pos_y, i_point_index);
        end
    end
endmodule

>>> bench/grid_cell_list_binner_tb.sv
// grid_cell_list_binner_tb: directed and random requests for the grid cell
// list binner with random gaps and several grid settings, verdict from
// gclb_checker. depends on gclb_pkg, gclb_checker and the block
module grid_cell_list_binner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        start = 0;
    logic [1:0]  command = gclb_pkg::CMD_ADD;
    logic [23:0] pos_x = 0, pos_y = 0;
    logic [5:0]  point_index = 0;
    logic        cfg_valid = 0;
    logic [1:0]  cfg_index = gclb_pkg::REG_ACROSS;
    logic [23:0] cfg_data = 0;
    wire         busy, valid, found, last, cfg_ready;
    wire  [1:0]  status;
    wire  [5:0]  point_out;
    wire  [7:0]  cell_out;
    int          errors, pending, points, results, hits;
    int          idle_cycles = 0, requests = 0;
    int          span_x, span_y;

    always #6 clk = ~clk;

    grid_cell_list_binner i_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .o_busy(busy),
        .i_command(command), .i_pos_x(pos_x), .i_pos_y(pos_y),
        .i_point_index(point_index), .o_valid(valid), .o_status(status),
        .o_found(found), .o_point_out(point_out), .o_cell_out(cell_out),
        .o_last(last), .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    gclb_checker i_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_busy(busy),
        .i_command(command), .i_pos_x(pos_x), .i_pos_y(pos_y),
        .i_point_index(point_index), .i_valid(valid), .i_status(status),
        .i_found(found), .i_point_out(point_out), .i_cell_out(cell_out),
        .i_last(last), .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data), .o_errors(errors),
        .o_pending(pending), .o_points(points), .o_results(results), .o_hits(hits)
    );

    // watchdog on cycles without any accepted transfer
    always @(posedge clk) begin
        if ((start && !busy) || valid || (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 3000) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_request(logic [1:0] cmd, logic [23:0] x, logic [23:0] y,
                                logic [5:0] idx);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) gap = 0;
        @(negedge clk);
        if (gap > 0) begin
            start = 0;
            repeat (gap) @(negedge clk);
        end
        command = cmd;
        pos_x = x;
        pos_y = y;
        point_index = idx;
        start = 1;
        // busy is stable at the falling edge: low means taken at the next rising edge
        while (busy) @(negedge clk);
        @(posedge clk);
        requests++;
    endtask

    task automatic drain();
        @(negedge clk);
        start = 0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] data);
        @(negedge clk);
        cfg_index = idx;
        cfg_data = data;
        cfg_valid = 1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    task automatic set_grid(int across, int down, int cw, int ch);
        longint sx, sy;
        int na, nd;
        drain();
        write_reg(gclb_pkg::REG_ACROSS, 24'(across));
        write_reg(gclb_pkg::REG_DOWN, 24'(down));
        write_reg(gclb_pkg::REG_WIDTH, 24'(cw));
        write_reg(gclb_pkg::REG_HEIGHT, 24'(ch));
        na = (across == 0) ? 1 : (across > 16) ? 16 : across;
        nd = (down == 0) ? 1 : (down > 16) ? 16 : down;
        sx = longint'(na + 1) * ((cw == 0) ? 1 : cw) - 1;
        sy = longint'(nd + 1) * ((ch == 0) ? 1 : ch) - 1;
        span_x = (sx > 24'hFFFFFF) ? 24'hFFFFFF : int'(sx);
        span_y = (sy > 24'hFFFFFF) ? 24'hFFFFFF : int'(sy);
    endtask

    task automatic random_phase(int n, int add_pct);
        int r;
        logic [1:0] cmd;
        logic [23:0] x, y;
        logic [5:0] idx;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < add_pct) cmd = gclb_pkg::CMD_ADD;
            else if (r < add_pct + (100 - add_pct) / 2) cmd = gclb_pkg::CMD_MOVE;
            else if (r < 96) cmd = gclb_pkg::CMD_QUERY;
            else cmd = gclb_pkg::CMD_NONE;
            if ($urandom_range(0, 9) == 0) begin
                x = 24'($urandom);
                y = 24'($urandom);
            end else begin
                x = 24'($urandom_range(0, span_x));
                y = 24'($urandom_range(0, span_y));
            end
            if ($urandom_range(0, 7) == 0 || points == 0) idx = 6'($urandom);
            else idx = 6'($urandom_range(0, points - 1));
            send_request(cmd, x, y, idx);
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        span_x = 217599;
        span_y = 217599;

        // directed: reset grid of 16 x 16 cells, 50.0 units each
        send_request(gclb_pkg::CMD_QUERY, 0, 0, 0);
        send_request(gclb_pkg::CMD_MOVE, 0, 0, 0);
        send_request(gclb_pkg::CMD_ADD, 0, 0, 6'h3F);
        send_request(gclb_pkg::CMD_ADD, 204799, 204799, 0);
        send_request(gclb_pkg::CMD_ADD, 204800, 204800, 0);
        send_request(gclb_pkg::CMD_ADD, 217599, 0, 0);
        send_request(gclb_pkg::CMD_ADD, 217600, 0, 0);
        send_request(gclb_pkg::CMD_ADD, 0, 24'hFFFFFF, 0);
        send_request(gclb_pkg::CMD_ADD, 24'hFFFFFF, 24'hFFFFFF, 0);
        send_request(gclb_pkg::CMD_ADD, 12800, 12800, 0);
        send_request(gclb_pkg::CMD_ADD, 12799, 25600, 0);
        send_request(gclb_pkg::CMD_MOVE, 0, 0, 6'h3F);
        send_request(gclb_pkg::CMD_MOVE, 0, 0, 5);
        send_request(gclb_pkg::CMD_MOVE, 100, 200, 0);
        send_request(gclb_pkg::CMD_MOVE, 25600, 0, 0);
        send_request(gclb_pkg::CMD_MOVE, 24'hFFFFFF, 0, 1);
        send_request(gclb_pkg::CMD_MOVE, 12800, 0, 4);
        send_request(gclb_pkg::CMD_QUERY, 12800, 12800, 0);
        send_request(gclb_pkg::CMD_QUERY, 204800, 204800, 0);
        send_request(gclb_pkg::CMD_QUERY, 100000, 100000, 0);
        send_request(gclb_pkg::CMD_QUERY, 24'hFFFFFF, 0, 0);
        send_request(gclb_pkg::CMD_NONE, 24'hFFFFFF, 24'hFFFFFF, 6'h3F);

        random_phase(50, 45);
        set_grid(1, 1, 256, 256);
        random_phase(80, 85);
        set_grid(4, 3, 1000, 50000);
        random_phase(60, 45);
        set_grid(0, 31, 0, 24'hFFFFFF);
        random_phase(50, 45);
        set_grid(16, 16, 24'hFFFFFF, 256);
        random_phase(60, 45);
        set_grid(3, 2, 3000, 3000);
        random_phase(80, 80);

        drain();
        repeat (300) @(posedge clk);
        $display("%0d requests over six grid settings, %0d results, %0d query hits",
                 requests, results, hits);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

>>> sim.f
rtl/gclb_pkg.sv
rtl/grid_cell_list_binner.sv
rtl/gclb_check.sv
bench/gclb_checker.sv
bench/grid_cell_list_binner_tb.sv
